/* hdl/btffa_pkg.sv */
// Shared types and constants for the boundary-tag first-fit allocator.
// No dependencies; imported by the tag RAM, the sequencer and the top level.
package btffa_pkg;

    localparam int OFF_W = 32;
    localparam int HEAP_BYTES_DEF = 262144;
    localparam int CHUNK_W = 19;
    localparam int REQ_W = 19;
    localparam int ADDR_W = 18;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef logic [OFF_W-1:0] off_t;

    localparam off_t SIZE_MASK = ~off_t'(7);
    localparam off_t ALLOC_BIT = off_t'(1);
    localparam off_t MIN_BLOCK = off_t'(16);
    localparam off_t FIRST_BP = off_t'(8);
    localparam off_t DSIZE = off_t'(8);
    localparam off_t PROLOGUE_END = 2 * DSIZE;
    localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(1 << 12);

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ZERO  = 2'd1,
        ST_NOMEM = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CTX_INIT,
        CTX_ALLOC,
        CTX_FREE
    } ctx_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT_W0,
        S_INIT_W1,
        S_INIT_W2,
        S_INIT_W3,
        S_GROW,
        S_GROW_WH,
        S_GROW_WF,
        S_GROW_WE,
        S_MRG_RH,
        S_MRG_RP,
        S_MRG_RN,
        S_MRG_DN,
        S_MRG_PS,
        S_MRG_WH,
        S_MRG_WF,
        S_FIT_RD,
        S_FIT_CK,
        S_CV_RD,
        S_CV_CK,
        S_CV_W1,
        S_CV_W2,
        S_CV_W3,
        S_CV_W4,
        S_FR_RD,
        S_FR_CK,
        S_FR_WH,
        S_FR_WF,
        S_DONE
    } state_t;

    // One tag access per cycle; offsets are byte offsets into the heap.
    typedef struct packed {
        logic re;
        logic we;
        off_t off;
        off_t wdata;
    } mem_req_t;

    localparam REG_CHUNK = 1'b0;

endpackage

/* hdl/boundary_tag_first_fit_allocator.sv */
// Boundary-tag first-fit allocator: APB chunk register, sequencer, tag RAM.
// Init lays out the prologue and grows the heap by one chunk; allocate walks the blocks for a
// first fit, splits it when the rest is large enough, and grows the heap when none fits; free
// merges with free neighbours. Each op waits to hand over its result while the result register is full.
// One item at a time, set by the single-port tag RAM (one tag access per cycle); a result
// register lets the next transfer be taken while a result waits. Reset: heap_end 0, chunk 4096.
module boundary_tag_first_fit_allocator
    import btffa_pkg::*;
#(
    parameter int HEAP_BYTES = HEAP_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic [REQ_W-1:0]   req_size,
    input  logic [ADDR_W-1:0]  block_addr,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ADDR_W-1:0]  result_addr,
    output logic [1:0]         status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [CHUNK_W-1:0] chunk_reg, chunk_next;
    mem_req_t           mreq;
    off_t               rdata;

    assign pready = 1'b1;

    always_comb
    begin
        chunk_next = chunk_reg;
        if (psel && penable && pwrite && pready && paddr[2] == REG_CHUNK)
        begin
            chunk_next = pwdata[CHUNK_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg <= CHUNK_RESET;
        end
        else
        begin
            chunk_reg <= chunk_next;
        end
    end

    assign prdata = (paddr[2] == REG_CHUNK) ? PDATA_W'(chunk_reg) : '0;

    btffa_seq #(
        .HEAP_BYTES(HEAP_BYTES)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .req_size   (req_size),
        .block_addr (block_addr),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_addr(result_addr),
        .status     (status),
        .chunk_bytes(chunk_reg),
        .mreq       (mreq),
        .rdata      (rdata)
    );

    btffa_tag_ram #(
        .HEAP_BYTES(HEAP_BYTES)
    ) u_ram (
        .clk  (clk),
        .rst_n(rst_n),
        .mreq (mreq),
        .rdata(rdata)
    );

    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mreq.re && mreq.we))
        else $error("tag RAM read and write in the same cycle");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken again while an item is in progress");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !(mreq.we || mreq.re))
        else $error("tag RAM accessed while sequencer idle");

endmodule

/* hdl/btffa_tag_ram.sv */
// Tag word memory: one synchronous port, read data registered.
// Offsets beyond the heap read zero and drop writes. Uses btffa_pkg.
module btffa_tag_ram
    import btffa_pkg::*;
#(
    parameter int HEAP_BYTES = HEAP_BYTES_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  mem_req_t mreq,
    output off_t     rdata
);

    localparam int WORDS = HEAP_BYTES / 4;
    localparam int AW = $clog2(WORDS);
    localparam int TW = $clog2(HEAP_BYTES) + 1;

    logic [TW-1:0] mem [WORDS];
    logic [TW-1:0] q_reg;
    logic          oob_reg;
    logic          oob_next;
    logic          in_range;
    logic [AW-1:0] idx;

    assign in_range = mreq.off[OFF_W-1:2] < (OFF_W-2)'(WORDS);
    assign idx = mreq.off[AW+1:2];
    assign oob_next = !in_range;

    always_ff @(posedge clk)
    begin
        if (mreq.we && in_range)
        begin
            mem[idx] <= mreq.wdata[TW-1:0];
        end
        if (mreq.re)
        begin
            q_reg <= mem[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oob_reg <= 1'b1;
        end
        else if (mreq.re)
        begin
            oob_reg <= oob_next;
        end
    end

    assign rdata = oob_reg ? '0 : OFF_W'(q_reg);

endmodule

/* hdl/btffa_seq.sv */
// Allocator sequencer: walks, splits, grows and merges blocks through the tag RAM,
// holds heap_end and the result register. Uses btffa_pkg.
module btffa_seq
    import btffa_pkg::*;
#(
    parameter int HEAP_BYTES = HEAP_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic [REQ_W-1:0]   req_size,
    input  logic [ADDR_W-1:0]  block_addr,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ADDR_W-1:0]  result_addr,
    output logic [1:0]         status,
    input  logic [CHUNK_W-1:0] chunk_bytes,
    output mem_req_t           mreq,
    input  off_t               rdata
);

    localparam off_t HB = off_t'(HEAP_BYTES);

    state_t            state_reg, state_next;
    ctx_t              ctx_reg, ctx_next;
    off_t              bp_reg, bp_next;
    off_t              size_reg, size_next;
    off_t              need_reg, need_next;
    off_t              prev_ft_reg, prev_ft_next;
    off_t              heap_end_reg, heap_end_next;
    off_t              res_reg, res_next;
    status_t           st_reg, st_next;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] result_addr_reg, result_addr_next;
    logic [1:0]        status_reg, status_next;

    off_t eff_chunk;
    off_t rd_size;
    off_t chunk_up;
    off_t req_need;
    logic merge_done;

    assign chunk_up = (off_t'(chunk_bytes) + off_t'(7)) & SIZE_MASK;
    assign eff_chunk = (chunk_up < MIN_BLOCK) ? MIN_BLOCK : chunk_up;
    assign rd_size = rdata & SIZE_MASK;
    assign req_need = ((off_t'(req_size) + off_t'(7)) & SIZE_MASK) + DSIZE;

    always_comb
    begin
        state_next = state_reg;
        ctx_next = ctx_reg;
        bp_next = bp_reg;
        size_next = size_reg;
        need_next = need_reg;
        prev_ft_next = prev_ft_reg;
        heap_end_next = heap_end_reg;
        res_next = res_reg;
        st_next = st_reg;
        out_valid_next = out_valid_reg;
        result_addr_next = result_addr_reg;
        status_next = status_reg;
        mreq = '0;
        merge_done = 1'b0;
        in_ready = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    res_next = '0;
                    st_next = ST_OK;
                    state_next = S_DONE;
                    unique case (op)
                        OP_INIT:
                        begin
                            heap_end_next = PROLOGUE_END;
                            ctx_next = CTX_INIT;
                            state_next = S_INIT_W0;
                        end
                        OP_ALLOC:
                        begin
                            if (req_size == '0)
                            begin
                                st_next = ST_ZERO;
                            end
                            else if (heap_end_reg == '0)
                            begin
                                st_next = ST_NOMEM;
                            end
                            else
                            begin
                                need_next = req_need;
                                bp_next = FIRST_BP;
                                ctx_next = CTX_ALLOC;
                                state_next = S_FIT_RD;
                            end
                        end
                        OP_FREE:
                        begin
                            if (heap_end_reg != '0 && block_addr[2:0] == 3'd0
                                && off_t'(block_addr) >= MIN_BLOCK
                                && off_t'(block_addr) < heap_end_reg)
                            begin
                                bp_next = off_t'(block_addr);
                                ctx_next = CTX_FREE;
                                state_next = S_FR_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            // padding, prologue header and footer, epilogue
            S_INIT_W0:
            begin
                mreq.we = 1'b1;
                mreq.off = off_t'(0);
                mreq.wdata = '0;
                state_next = S_INIT_W1;
            end
            S_INIT_W1:
            begin
                mreq.we = 1'b1;
                mreq.off = off_t'(4);
                mreq.wdata = DSIZE | ALLOC_BIT;
                state_next = S_INIT_W2;
            end
            S_INIT_W2:
            begin
                mreq.we = 1'b1;
                mreq.off = DSIZE;
                mreq.wdata = DSIZE | ALLOC_BIT;
                state_next = S_INIT_W3;
            end
            S_INIT_W3:
            begin
                mreq.we = 1'b1;
                mreq.off = off_t'(12);
                mreq.wdata = ALLOC_BIT;
                size_next = eff_chunk;
                state_next = S_GROW;
            end
            S_GROW:
            begin
                if (size_reg > HB - heap_end_reg)
                begin
                    st_next = ST_NOMEM;
                    res_next = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    bp_next = heap_end_reg;
                    heap_end_next = heap_end_reg + size_reg;
                    state_next = S_GROW_WH;
                end
            end
            S_GROW_WH:
            begin
                mreq.we = 1'b1;
                mreq.off = bp_reg - off_t'(4);
                mreq.wdata = size_reg;
                state_next = S_GROW_WF;
            end
            S_GROW_WF:
            begin
                mreq.we = 1'b1;
                mreq.off = bp_reg + size_reg - DSIZE;
                mreq.wdata = size_reg;
                state_next = S_GROW_WE;
            end
            S_GROW_WE:
            begin
                mreq.we = 1'b1;
                mreq.off = bp_reg + size_reg - off_t'(4);
                mreq.wdata = ALLOC_BIT;
                state_next = S_MRG_RH;
            end
            // reads are issued back to back; each state consumes the previous one
            S_MRG_RH:
            begin
                mreq.re = 1'b1;
                mreq.off = bp_reg - off_t'(4);
                state_next = S_MRG_RP;
            end
            S_MRG_RP:
            begin
                size_next = rd_size;
                mreq.re = 1'b1;
                mreq.off = bp_reg - DSIZE;
                state_next = S_MRG_RN;
            end
            S_MRG_RN:
            begin
                prev_ft_next = rdata;
                mreq.re = 1'b1;
                mreq.off = bp_reg + size_reg - off_t'(4);
                state_next = S_MRG_DN;
            end
            S_MRG_DN:
            begin
                if (prev_ft_reg[0] && rdata[0])
                begin
                    merge_done = 1'b1;
                end
                else
                begin
                    size_next = size_reg + (rdata[0] ? '0 : rd_size);
                    if (!prev_ft_reg[0])
                    begin
                        bp_next = bp_reg - (prev_ft_reg & SIZE_MASK);
                        mreq.re = 1'b1;
                        mreq.off = bp_reg - (prev_ft_reg & SIZE_MASK) - off_t'(4);
                        state_next = S_MRG_PS;
                    end
                    else
                    begin
                        state_next = S_MRG_WH;
                    end
                end
            end
            S_MRG_PS:
            begin
                size_next = size_reg + rd_size;
                state_next = S_MRG_WH;
            end
            S_MRG_WH:
            begin
                mreq.we = 1'b1;
                mreq.off = bp_reg - off_t'(4);
                mreq.wdata = size_reg;
                state_next = S_MRG_WF;
            end
            S_MRG_WF:
            begin
                mreq.we = 1'b1;
                mreq.off = bp_reg + size_reg - DSIZE;
                mreq.wdata = size_reg;
                merge_done = 1'b1;
            end
            S_FIT_RD:
            begin
                mreq.re = 1'b1;
                mreq.off = bp_reg - off_t'(4);
                state_next = S_FIT_CK;
            end
            // one block per cycle: advance and read the next header at once
            S_FIT_CK:
            begin
                if (rd_size == '0 || bp_reg >= heap_end_reg)
                begin
                    size_next = (need_reg > eff_chunk) ? need_reg : eff_chunk;
                    state_next = S_GROW;
                end
                else if (!rdata[0] && rd_size >= need_reg)
                begin
                    state_next = S_CV_RD;
                end
                else
                begin
                    bp_next = bp_reg + rd_size;
                    mreq.re = 1'b1;
                    mreq.off = bp_reg + rd_size - off_t'(4);
                end
            end
            S_CV_RD:
            begin
                mreq.re = 1'b1;
                mreq.off = bp_reg - off_t'(4);
                state_next = S_CV_CK;
            end
            S_CV_CK:
            begin
                if (rd_size - need_reg < MIN_BLOCK)
                begin
                    need_next = rd_size;
                    size_next = '0;
                end
                else
                begin
                    size_next = rd_size - need_reg;
                end
                state_next = S_CV_W1;
            end
            S_CV_W1:
            begin
                mreq.we = 1'b1;
                mreq.off = bp_reg - off_t'(4);
                mreq.wdata = need_reg | ALLOC_BIT;
                state_next = S_CV_W2;
            end
            S_CV_W2:
            begin
                mreq.we = 1'b1;
                mreq.off = bp_reg + need_reg - DSIZE;
                mreq.wdata = need_reg | ALLOC_BIT;
                if (size_reg != '0)
                begin
                    state_next = S_CV_W3;
                end
                else
                begin
                    st_next = ST_OK;
                    res_next = bp_reg;
                    state_next = S_DONE;
                end
            end
            S_CV_W3:
            begin
                mreq.we = 1'b1;
                mreq.off = bp_reg + need_reg - off_t'(4);
                mreq.wdata = size_reg;
                state_next = S_CV_W4;
            end
            S_CV_W4:
            begin
                mreq.we = 1'b1;
                mreq.off = bp_reg + need_reg + size_reg - DSIZE;
                mreq.wdata = size_reg;
                st_next = ST_OK;
                res_next = bp_reg;
                state_next = S_DONE;
            end
            S_FR_RD:
            begin
                mreq.re = 1'b1;
                mreq.off = bp_reg - off_t'(4);
                state_next = S_FR_CK;
            end
            S_FR_CK:
            begin
                size_next = rd_size;
                state_next = S_FR_WH;
            end
            S_FR_WH:
            begin
                mreq.we = 1'b1;
                mreq.off = bp_reg - off_t'(4);
                mreq.wdata = size_reg;
                state_next = S_FR_WF;
            end
            S_FR_WF:
            begin
                mreq.we = 1'b1;
                mreq.off = bp_reg + size_reg - DSIZE;
                mreq.wdata = size_reg;
                state_next = S_MRG_RH;
            end
            // hold until the result register is free
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    result_addr_next = res_reg[ADDR_W-1:0];
                    status_next = st_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (merge_done)
        begin
            res_next = '0;
            state_next = S_DONE;
            unique case (ctx_reg)
                CTX_INIT:
                begin
                    st_next = (bp_reg == '0) ? ST_NOMEM : ST_OK;
                end
                CTX_ALLOC:
                begin
                    if (bp_reg == '0)
                    begin
                        st_next = ST_NOMEM;
                    end
                    else
                    begin
                        state_next = S_CV_RD;
                    end
                end
                CTX_FREE:
                begin
                    st_next = ST_OK;
                end
                default:
                begin
                    st_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            heap_end_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            heap_end_reg <= heap_end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg <= ctx_next;
        bp_reg <= bp_next;
        size_reg <= size_next;
        need_reg <= need_next;
        prev_ft_reg <= prev_ft_next;
        res_reg <= res_next;
        st_reg <= st_next;
        result_addr_reg <= result_addr_next;
        status_reg <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign result_addr = result_addr_reg;
    assign status = status_reg;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the boundary-tag first-fit allocator.
// Depends on btffa_pkg and boundary_tag_first_fit_allocator; a small class predicts
// the tag heap and queues the expected results, plain tasks drive APB and the input.
module tb_top;
    import btffa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int unsigned HEAP_WORDS = HEAP_BYTES_DEF / 4;
    localparam int unsigned CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [1:0]        st;
    } alloc_result_t;

    class heap_scoreboard;
        bit [31:0] tags [int unsigned];
        int unsigned heap_end;
        int unsigned chunk;
        alloc_result_t pending_q[$];
        int errors;
        int n_alloc_ok, n_nomem, n_zero, n_free, n_init, n_checked;

        function new();
            heap_end = 0;
            chunk = 4096;
            errors = 0;
        endfunction

        function bit [31:0] rd(int unsigned off);
            int unsigned i;
            i = off >> 2;
            if (i >= HEAP_WORDS || !tags.exists(i))
                return 0;
            return tags[i];
        endfunction

        function void wr(int unsigned off, bit [31:0] v);
            int unsigned i;
            i = off >> 2;
            if (i < HEAP_WORDS)
                tags[i] = v;
        endfunction

        function int unsigned size_at(int unsigned bp);
            return rd(bp - 4) & SIZE_MASK;
        endfunction

        function void set_tags(int unsigned bp, int unsigned sz, bit a);
            wr(bp - 4, sz | a);
            wr(bp + sz - 8, sz | a);
        endfunction

        function int unsigned coalesce(int unsigned bp);
            int unsigned sz, prev_ft, prev_bp, next_bp;
            bit prev_a, next_a;
            sz = size_at(bp);
            prev_ft = rd(bp - 8);
            prev_bp = bp - (prev_ft & SIZE_MASK);
            next_bp = bp + sz;
            prev_a = prev_ft[0];
            next_a = rd(next_bp - 4) & 1;
            if (prev_a && next_a)
                return bp;
            if (!next_a)
                sz += size_at(next_bp);
            if (!prev_a) begin
                sz += size_at(prev_bp);
                bp = prev_bp;
            end
            set_tags(bp, sz, 0);
            return bp;
        endfunction

        function int unsigned extend(int unsigned sz);
            int unsigned bp;
            bp = heap_end;
            if (sz > HEAP_BYTES_DEF - heap_end)
                return 0;
            heap_end += sz;
            set_tags(bp, sz, 0);
            wr(bp + sz - 4, 1);
            return coalesce(bp);
        endfunction

        function int unsigned grow_step();
            int unsigned c;
            c = (chunk + 7) & SIZE_MASK;
            return (c < MIN_BLOCK) ? MIN_BLOCK : c;
        endfunction

        // Predict one transfer; returns the predicted allocation address.
        function logic [ADDR_W-1:0] note_transfer(logic [1:0] op, logic [REQ_W-1:0] req,
                                                  logic [ADDR_W-1:0] baddr);
            alloc_result_t r;
            int unsigned need, bp, h, sz, rest, c;
            r.addr = '0;
            r.st = ST_OK;
            if (op == OP_INIT) begin
                n_init++;
                heap_end = 16;
                wr(0, 0);
                wr(4, 9);
                wr(8, 9);
                wr(12, 1);
                if (extend(grow_step()) == 0)
                    r.st = ST_NOMEM;
            end else if (op == OP_ALLOC) begin
                if (req == 0) begin
                    r.st = ST_ZERO;
                end else if (heap_end == 0) begin
                    r.st = ST_NOMEM;
                end else begin
                    need = ((int'(req) + 7) & SIZE_MASK) + 8;
                    bp = FIRST_BP;
                    forever begin
                        h = rd(bp - 4);
                        sz = h & SIZE_MASK;
                        if (sz == 0 || bp >= heap_end) begin
                            bp = 0;
                            break;
                        end
                        if (!h[0] && sz >= need)
                            break;
                        bp += sz;
                    end
                    if (bp == 0) begin
                        c = grow_step();
                        bp = extend(need > c ? need : c);
                    end
                    if (bp == 0) begin
                        r.st = ST_NOMEM;
                    end else begin
                        sz = size_at(bp);
                        rest = sz - need;
                        if (rest < MIN_BLOCK) begin
                            need = sz;
                            rest = 0;
                        end
                        set_tags(bp, need, 1'b1);
                        if (rest > 0)
                            set_tags(bp + need, rest, 1'b0);
                        r.addr = ADDR_W'(bp);
                    end
                end
                if (r.st == ST_OK) n_alloc_ok++;
                else if (r.st == ST_ZERO) n_zero++;
                else n_nomem++;
            end else if (op == OP_FREE) begin
                n_free++;
                if (heap_end != 0 && baddr[2:0] == 0 && baddr >= 16 && baddr < heap_end) begin
                    set_tags(baddr, size_at(baddr), 1'b0);
                    void'(coalesce(baddr));
                end
            end
            pending_q.push_back(r);
            return r.addr;
        endfunction

        function void check_result(logic [ADDR_W-1:0] a, logic [1:0] s);
            alloc_result_t e;
            if (pending_q.size() == 0) begin
                $error("result with nothing expected: result_addr=%0d status=%0d", a, s);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            n_checked++;
            if (a !== e.addr) begin
                $error("result_addr mismatch: expected %0d actual %0d", e.addr, a);
                errors++;
            end
            if (s !== e.st) begin
                $error("status mismatch: expected %0d actual %0d", e.st, s);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         op;
    logic [REQ_W-1:0]   req_size;
    logic [ADDR_W-1:0]  block_addr;
    logic               out_valid;
    logic               out_ready;
    logic [ADDR_W-1:0]  result_addr;
    logic [1:0]         status;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    heap_scoreboard sb;
    int unsigned cycles;
    int burst_left;
    logic [ADDR_W-1:0] live_blocks[$];

    boundary_tag_first_fit_allocator uut (.*);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver stalls on a pattern that steps through four modes in turn.
    always @(posedge clk) begin
        case ((cycles >> 9) % 4)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= ((cycles % 16) < 3);
            default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(result_addr, status);
    end

    task automatic send_item(logic [1:0] o, logic [REQ_W-1:0] rq, logic [ADDR_W-1:0] ba);
        int gap;
        logic [ADDR_W-1:0] got;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        op <= o;
        req_size <= rq;
        block_addr <= ba;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        got = sb.note_transfer(o, rq, ba);
        if (o == OP_INIT)
            live_blocks.delete();
        else if (o == OP_ALLOC && got != 0)
            live_blocks.push_back(got);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_chunk(logic [PDATA_W-1:0] v);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= PADDR_W'({REG_CHUNK, 2'b00});
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.chunk = v & 32'h7FFFF;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic free_live();
        int k;
        logic [ADDR_W-1:0] a;
        k = $urandom_range(0, live_blocks.size() - 1);
        a = live_blocks[k];
        live_blocks.delete(k);
        send_item(OP_FREE, REQ_W'($urandom), a);
    endtask

    // Free that the block must ignore: before init, misaligned, too low or past the end.
    task automatic free_ignored();
        logic [ADDR_W-1:0] a;
        a = ADDR_W'($urandom);
        if (sb.heap_end != 0) begin
            case ($urandom_range(0, 2))
                0: if (a[2:0] == 0) a[2:0] = 3'($urandom_range(1, 7));
                1: a = ADDR_W'($urandom_range(0, 15));
                default:
                    if (sb.heap_end < HEAP_BYTES_DEF)
                        a = ADDR_W'($urandom_range(sb.heap_end, HEAP_BYTES_DEF - 1));
                    else
                        a[0] = 1'b1;
            endcase
        end
        send_item(OP_FREE, REQ_W'($urandom), a);
    endtask

    task automatic random_phase(int n);
        int pick;
        logic [REQ_W-1:0] rq;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (live_blocks.size() > 48 || (pick < 38 && live_blocks.size() > 0)) begin
                free_live();
            end else if (pick < 82) begin
                case ($urandom_range(0, 19))
                    0: rq = REQ_W'($urandom);
                    1, 2: rq = REQ_W'($urandom_range(1, 16384));
                    3: rq = 19'd262144;
                    default: rq = REQ_W'($urandom_range(1, 200));
                endcase
                send_item(OP_ALLOC, rq, ADDR_W'($urandom));
            end else if (pick < 88) begin
                free_ignored();
            end else if (pick < 92) begin
                send_item(OP_ALLOC, '0, ADDR_W'($urandom));
            end else if (pick < 95) begin
                send_item(OP_UNUSED, REQ_W'($urandom), ADDR_W'($urandom));
            end else begin
                send_item(OP_INIT, REQ_W'($urandom), ADDR_W'($urandom));
            end
        end
    endtask

    initial begin
        logic [PDATA_W-1:0] chunks[$];
        sb = new();
        cycles = 0;
        burst_left = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = '0;
        req_size = '0;
        block_addr = '0;
        out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: use before init, odd ops, size extremes, exact fit and frees.
        send_item(OP_ALLOC, 19'd24, '0);
        send_item(OP_FREE, '0, 18'd16);
        send_item(OP_UNUSED, 19'h7FFFF, 18'h3FFFF);
        send_item(OP_INIT, '0, '0);
        send_item(OP_ALLOC, '0, '0);
        send_item(OP_ALLOC, 19'd1, '0);
        send_item(OP_ALLOC, 19'd262144, '0);
        send_item(OP_ALLOC, 19'h7FFFF, '0);
        send_item(OP_ALLOC, 19'd4072, '0);
        send_item(OP_ALLOC, 19'd8, '0);
        send_item(OP_ALLOC, 19'd100, '0);
        send_item(OP_FREE, '0, 18'd13);
        send_item(OP_FREE, '0, 18'd8);
        send_item(OP_FREE, '0, 18'h3FFFF);
        while (live_blocks.size() > 0) free_live();
        send_item(OP_ALLOC, 19'd4000, '0);
        send_item(OP_ALLOC, 19'd300000, '0);
        send_item(OP_INIT, '0, '0);

        chunks = '{32'd4096, 32'd16, 32'd262144, 32'd0, 32'd13, 32'h7FFFF,
                   32'd100, 32'hFFFF_FFF8, 32'd8192};
        chunks.push_back(($urandom_range(2, 4096) * 8));
        foreach (chunks[i]) begin
            write_chunk(chunks[i]);
            send_item(OP_INIT, REQ_W'($urandom), ADDR_W'($urandom));
            random_phase(190);
        end
        drain();

        $display("covered %0d inits, %0d allocations (%0d nomem, %0d zero), %0d frees",
                 sb.n_init, sb.n_alloc_ok, sb.n_nomem, sb.n_zero, sb.n_free);
        $display("checked %0d results over %0d chunk settings", sb.n_checked, chunks.size());
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
